// File: sv/cpq_pkg.sv
// ----------------------------------------------------------------------------
// cpq_pkg
// shared constants and types of the class priority byte limited queue
// ----------------------------------------------------------------------------
package cpq_pkg;

  localparam int QueueDepth = 64;
  localparam int BytesW     = 22;
  localparam int TagW       = 16;
  localparam int SizeW      = 16;
  localparam int ClassW     = 3;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  localparam logic [ClassW-1:0] CLS_SIM_ACK  = 3'd0;
  localparam logic [ClassW-1:0] CLS_SIM      = 3'd1;
  localparam logic [ClassW-1:0] CLS_DATA_ACK = 3'd2;
  localparam logic [ClassW-1:0] CLS_DATA     = 3'd3;

  localparam logic [BytesW-1:0] LIMIT_RESET = 22'd65536;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_APPLY
  } state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_item;
    logic find;
    logic apply;
  } cmd_t;

endpackage

// File: sv/cpq_in_if.sv
// ----------------------------------------------------------------------------
// cpq_in_if
// request channel: enqueue or dequeue items
// ----------------------------------------------------------------------------
interface cpq_in_if import cpq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [TagW-1:0]   pkt_tag;
  logic [SizeW-1:0]  pkt_size;
  logic [ClassW-1:0] pkt_class;
  logic              pkt_invalid;

  modport source (output valid, kind, pkt_tag, pkt_size, pkt_class, pkt_invalid,
                  input ready);
  modport sink   (input valid, kind, pkt_tag, pkt_size, pkt_class, pkt_invalid,
                  output ready);
endinterface

// File: sv/cpq_out_if.sv
// ----------------------------------------------------------------------------
// cpq_out_if
// result channel: one result per request
// ----------------------------------------------------------------------------
interface cpq_out_if import cpq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              dropped;
  logic              empty_res;
  logic [TagW-1:0]   out_tag;
  logic [SizeW-1:0]  out_size;
  logic [ClassW-1:0] out_class;

  modport source (output valid, dropped, empty_res, out_tag, out_size, out_class,
                  input ready);
  modport sink   (input valid, dropped, empty_res, out_tag, out_size, out_class,
                  output ready);
endinterface

// File: sv/cpq_cfg_if.sv
// ----------------------------------------------------------------------------
// cpq_cfg_if
// configuration write channel for the byte limit
// ----------------------------------------------------------------------------
interface cpq_cfg_if import cpq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BytesW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: sv/cpq_ctrl.sv
// ----------------------------------------------------------------------------
// cpq_ctrl
// sequencing of one item: load, priority search, update and result
// ----------------------------------------------------------------------------
module cpq_ctrl import cpq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_FIND;
      ST_FIND:  state_d = ST_APPLY;
      ST_APPLY: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      ST_FIND:  cmd_o.find  = 1'b1;
      ST_APPLY: cmd_o.apply = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.apply) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: sv/cpq_datapath.sv
// ----------------------------------------------------------------------------
// cpq_datapath
// cell chain of queued packets, byte accounting and result register
// ----------------------------------------------------------------------------
module cpq_datapath import cpq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic              kind_i,
  input  logic [TagW-1:0]   tag_i,
  input  logic [SizeW-1:0]  size_i,
  input  logic [ClassW-1:0] class_i,
  input  logic              invalid_i,
  input  logic              cfg_we_i,
  input  logic [BytesW-1:0] cfg_data_i,
  output logic              dropped_o,
  output logic              empty_o,
  output logic [TagW-1:0]   tag_o,
  output logic [SizeW-1:0]  size_o,
  output logic [ClassW-1:0] class_o
);

  // held item
  logic              kind_q;
  logic [TagW-1:0]   tag_q;
  logic [SizeW-1:0]  size_q;
  logic [ClassW-1:0] class_q;
  logic              inv_q;

  // cell chain, oldest in cell 0
  logic [TagW-1:0]   c_tag_q   [QueueDepth];
  logic [SizeW-1:0]  c_size_q  [QueueDepth];
  logic [ClassW-1:0] c_class_q [QueueDepth];
  logic [QueueDepth-1:0] vld_q, vld_d;

  logic [BytesW-1:0] bytes_q, bytes_d, limit_q;
  logic [QueueDepth-1:0] pick_q;

  logic [QueueDepth-1:0] hit0, hit1, hit2, hit3, cand, ge, target;
  logic [TagW-1:0]   sel_tag;
  logic [SizeW-1:0]  sel_size;
  logic [ClassW-1:0] sel_class;
  logic [BytesW:0]   sum;
  logic              enq_ok, is_empty;

  // per-cell class match, then the best class present
  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      hit0[i] = vld_q[i] && (c_class_q[i] == CLS_SIM_ACK);
      hit1[i] = vld_q[i] && (c_class_q[i] == CLS_SIM);
      hit2[i] = vld_q[i] && (c_class_q[i] == CLS_DATA_ACK);
      hit3[i] = vld_q[i] && (c_class_q[i] == CLS_DATA);
    end
    if (|hit0)      cand = hit0;
    else if (|hit1) cand = hit1;
    else if (|hit2) cand = hit2;
    else if (|hit3) cand = hit3;
    else            cand = {{(QueueDepth-1){1'b0}}, 1'b1};
  end

  // pick marks the removed cell, ge every cell from it upwards
  assign ge = ~(pick_q - {{(QueueDepth-1){1'b0}}, 1'b1});

  always_comb begin
    sel_tag   = '0;
    sel_size  = '0;
    sel_class = '0;
    for (int i = 0; i < QueueDepth; i++) begin
      if (pick_q[i]) begin
        sel_tag   = sel_tag   | c_tag_q[i];
        sel_size  = sel_size  | c_size_q[i];
        sel_class = sel_class | c_class_q[i];
      end
    end
    for (int i = 0; i < QueueDepth; i++) begin
      target[i] = !vld_q[i] && ((i == 0) || vld_q[(i == 0) ? 0 : i-1]);
    end
  end

  assign sum      = {1'b0, bytes_q} + {{(BytesW+1-SizeW){1'b0}}, size_q};
  assign enq_ok   = !inv_q && (sum <= {1'b0, limit_q}) && !vld_q[QueueDepth-1];
  assign is_empty = (bytes_q == '0) || !vld_q[0];

  always_comb begin
    vld_d   = vld_q;
    bytes_d = bytes_q;
    if (cmd_i.apply) begin
      if (kind_q == KIND_ENQ) begin
        if (enq_ok) begin
          vld_d   = vld_q | target;
          bytes_d = sum[BytesW-1:0];
        end
      end else if (!is_empty) begin
        for (int i = 0; i < QueueDepth; i++) begin
          if (ge[i]) vld_d[i] = (i < QueueDepth-1) ? vld_q[(i < QueueDepth-1) ? i+1 : i]
                                                   : 1'b0;
        end
        bytes_d = ({{(BytesW-SizeW){1'b0}}, sel_size} <= bytes_q)
                ? bytes_q - {{(BytesW-SizeW){1'b0}}, sel_size} : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      bytes_q <= '0;
      limit_q <= LIMIT_RESET;
    end else begin
      vld_q   <= vld_d;
      bytes_q <= bytes_d;
      if (cfg_we_i) limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q  <= kind_i;
      tag_q   <= tag_i;
      size_q  <= size_i;
      class_q <= class_i;
      inv_q   <= invalid_i;
    end
    if (cmd_i.find) pick_q <= cand & (~cand + {{(QueueDepth-1){1'b0}}, 1'b1});
    if (cmd_i.apply) begin
      for (int i = 0; i < QueueDepth; i++) begin
        if (kind_q == KIND_ENQ) begin
          if (enq_ok && target[i]) begin
            c_tag_q[i]   <= tag_q;
            c_size_q[i]  <= size_q;
            c_class_q[i] <= class_q;
          end
        end else if (!is_empty && ge[i] && (i < QueueDepth-1)) begin
          c_tag_q[i]   <= c_tag_q[(i < QueueDepth-1) ? i+1 : i];
          c_size_q[i]  <= c_size_q[(i < QueueDepth-1) ? i+1 : i];
          c_class_q[i] <= c_class_q[(i < QueueDepth-1) ? i+1 : i];
        end
      end
      dropped_o <= (kind_q == KIND_ENQ) && !enq_ok;
      empty_o   <= (kind_q == KIND_DEQ) && is_empty;
      if ((kind_q == KIND_DEQ) && !is_empty) begin
        tag_o   <= sel_tag;
        size_o  <= sel_size;
        class_o <= sel_class;
      end else begin
        tag_o   <= '0;
        size_o  <= '0;
        class_o <= '0;
      end
    end
  end

endmodule

// File: sv/class_priority_byte_limited_queue.sv
// ----------------------------------------------------------------------------
// class_priority_byte_limited_queue
// strict class priority packet queue with byte budget and tail drop
// ----------------------------------------------------------------------------
// Each request gives exactly one result. A request is loaded at its transfer,
// then takes a priority search step over the cell chain and an update step,
// which waits while an earlier result is still untaken; the result is
// registered by the update. No new request is taken until that update,
// but the next request is accepted while the previous result still waits
// in the output register. Held packets sit in a chain of QueueDepth cells,
// oldest first; a dequeue picks the oldest packet of class sim ack, sim,
// data ack, data in that order, else the oldest packet, and the cells above
// close up in that update. An enqueue is dropped when marked invalid, when
// it would take the held bytes over the limit, or when every cell is in use.
// A dequeue reports empty when no bytes are held or no cell is in use. The
// byte limit resets to 65536 and the configuration port is always ready.
module class_priority_byte_limited_queue import cpq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  cpq_in_if.sink    in_i,
  cpq_out_if.source out_o,
  cpq_cfg_if.sink   cfg_i
);

  cmd_t cmd;

  // configuration writes land straight in the limit register
  assign cfg_i.ready = 1'b1;

  cpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  cpq_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .kind_i     (in_i.kind),
    .tag_i      (in_i.pkt_tag),
    .size_i     (in_i.pkt_size),
    .class_i    (in_i.pkt_class),
    .invalid_i  (in_i.pkt_invalid),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.data),
    .dropped_o  (out_o.dropped),
    .empty_o    (out_o.empty_res),
    .tag_o      (out_o.out_tag),
    .size_o     (out_o.out_size),
    .class_o    (out_o.out_class)
  );

  // only one step of the sequence at a time
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_item, cmd.find, cmd.apply}))
    else $error("more than one command at once");

  // an update always leaves a result behind
  a_apply_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.apply |=> out_o.valid)
    else $error("update without result");

  // after a request transfer no second one until the item is done
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request taken while busy");

endmodule

// File: dv/class_priority_byte_limited_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// class_priority_byte_limited_queue_tb
// random and directed check of the class priority queue against a predictor
// of its own; requests and results move with random gaps, the byte limit is
// changed between phases while the block is idle
// ----------------------------------------------------------------------------

// software image of the queue: predicts one result per request
class pq_scoreboard;
  typedef struct packed {
    logic                       dropped;
    logic                       empty_res;
    logic [cpq_pkg::TagW-1:0]   tag;
    logic [cpq_pkg::SizeW-1:0]  size;
    logic [cpq_pkg::ClassW-1:0] cls;
  } result_t;
  typedef struct packed {
    logic [cpq_pkg::TagW-1:0]   tag;
    logic [cpq_pkg::SizeW-1:0]  size;
    logic [cpq_pkg::ClassW-1:0] cls;
  } pkt_t;

  pkt_t    held_pkts[$];
  int      bytes_held;
  int      byte_limit;
  result_t pending[$];
  int      mismatches;
  int      n_results;
  int      n_drops;
  int      n_empty;

  function new();
    bytes_held = 0;
    byte_limit = cpq_pkg::LIMIT_RESET;
    mismatches = 0;
    n_results  = 0;
    n_drops    = 0;
    n_empty    = 0;
  endfunction

  function void note_request(logic kind, logic [15:0] tag, logic [15:0] size,
                             logic [2:0] cls, logic bad);
    result_t r;
    pkt_t    p;
    int      k;
    r = '0;
    if (kind == cpq_pkg::KIND_ENQ) begin
      if (!bad && bytes_held + size <= byte_limit &&
          held_pkts.size() < cpq_pkg::QueueDepth) begin
        p.tag = tag; p.size = size; p.cls = cls;
        held_pkts.insert(held_pkts.size(), p);
        bytes_held += size;
      end else begin
        r.dropped = 1'b1;
      end
    end else if (bytes_held == 0 || held_pkts.size() == 0) begin
      r.empty_res = 1'b1;
    end else begin
      k = -1;
      for (int c = 0; c < 4 && k < 0; c++)
        for (int i = 0; i < held_pkts.size() && k < 0; i++)
          if (held_pkts[i].cls == c) k = i;
      if (k < 0) k = 0;
      p = held_pkts[k];
      held_pkts.delete(k);
      bytes_held = (p.size <= bytes_held) ? bytes_held - p.size : 0;
      r.tag = p.tag; r.size = p.size; r.cls = p.cls;
    end
    pending.insert(pending.size(), r);
  endfunction

  function void check_result(result_t got);
    result_t want;
    n_results++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    want = pending[0];
    pending.delete(0);
    if (got.dropped) n_drops++;
    if (got.empty_res) n_empty++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: drop %b/%b empty %b/%b tag %h/%h size %h/%h cls %0d/%0d",
                 want.dropped, got.dropped, want.empty_res, got.empty_res,
                 want.tag, got.tag, want.size, got.size, want.cls, got.cls);
    end
  endfunction
endclass

module class_priority_byte_limited_queue_tb;
  import cpq_pkg::*;

  localparam int StallLimit = 20000;

  logic clk_i;
  logic rst_ni;

  cpq_in_if  req_if ();
  cpq_out_if res_if ();
  cpq_cfg_if cfg_if ();

  class_priority_byte_limited_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if.sink),
    .out_o  (res_if.source),
    .cfg_i  (cfg_if.sink)
  );

  pq_scoreboard board;
  bit           calm;          // no random idling on either side
  int           hold_off;      // receiver long stall, in cycles
  int           idle_cycles;
  bit           timed_out;

  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  // result side: sample at the rising edge, change ready at the falling edge
  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready)
      board.check_result({res_if.dropped, res_if.empty_res, res_if.out_tag,
                          res_if.out_size, res_if.out_class});
  end

  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= calm || ($urandom_range(99) >= 10);
    end
  end

  // watchdog: cycles with no transfer on any channel
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("Regression FAIL");
      $finish;
    end
  end

  // one request transfer, with an optional random gap before it; valid
  // stays high after the transfer until the next gap or a drain
  task automatic send_request(logic kind, logic [15:0] tag, logic [15:0] size,
                              logic [2:0] cls, logic bad);
    while (!calm && $urandom_range(99) < 10) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.kind        <= kind;
    req_if.pkt_tag     <= tag;
    req_if.pkt_size    <= size;
    req_if.pkt_class   <= cls;
    req_if.pkt_invalid <= bad;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    board.note_request(kind, tag, size, cls, bad);
    @(negedge clk_i);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  // byte limit write, only with the block idle
  task automatic set_limit(logic [21:0] value);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    board.byte_limit = int'(value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // enqueues at the given percentage, mostly small sizes, sometimes large or poisoned
  task automatic random_request(int enq_pct);
    logic [15:0] size;
    if ($urandom_range(99) < enq_pct) begin
      case ($urandom_range(3))
        0:       size = 16'($urandom);
        1:       size = 16'd0;
        default: size = 16'($urandom_range(2000));
      endcase
      send_request(KIND_ENQ, 16'($urandom), size, 3'($urandom_range(7)),
                   $urandom_range(19) == 0);
    end else begin
      send_request(KIND_DEQ, 16'($urandom), 16'($urandom), 3'($urandom_range(7)),
                   1'($urandom));
    end
  endtask

  initial begin
    board        = new();
    calm         = 1'b0;
    hold_off     = 0;
    idle_cycles  = 0;
    timed_out    = 1'b0;
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.kind  = KIND_ENQ;
    req_if.pkt_tag     = '0;
    req_if.pkt_size    = '0;
    req_if.pkt_class   = '0;
    req_if.pkt_invalid = 1'b0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty dequeue, the four named classes and unnamed ones, priority order, poisoned packet
    send_request(KIND_DEQ, 16'hffff, 16'hffff, 3'd7, 1'b1);
    send_request(KIND_ENQ, 16'h0001, 16'd100, 3'd4, 1'b0);
    send_request(KIND_ENQ, 16'h0002, 16'd200, CLS_DATA, 1'b0);
    send_request(KIND_ENQ, 16'h0003, 16'd300, CLS_DATA_ACK, 1'b0);
    send_request(KIND_ENQ, 16'h0004, 16'd400, CLS_SIM, 1'b0);
    send_request(KIND_ENQ, 16'h0005, 16'd500, CLS_SIM_ACK, 1'b0);
    send_request(KIND_ENQ, 16'h0006, 16'd600, 3'd7, 1'b0);
    send_request(KIND_ENQ, 16'h0007, 16'd10, CLS_SIM, 1'b1);
    repeat (7) send_request(KIND_DEQ, 16'h0, 16'h0, 3'd0, 1'b0);
    // zero-size packets read as empty
    send_request(KIND_ENQ, 16'hffff, 16'd0, CLS_SIM_ACK, 1'b0);
    send_request(KIND_DEQ, 16'h0, 16'h0, 3'd0, 1'b0);
    // limit over the top, exact fit at the edge of the budget
    send_request(KIND_ENQ, 16'h0010, 16'hffff, CLS_DATA, 1'b0);
    send_request(KIND_ENQ, 16'h0011, 16'd1, CLS_DATA, 1'b0);
    send_request(KIND_ENQ, 16'h0012, 16'd2, CLS_DATA, 1'b0);
    // zero limit: lowered below held bytes
    set_limit(22'd0);
    send_request(KIND_ENQ, 16'h0020, 16'd0, CLS_SIM, 1'b0);
    send_request(KIND_ENQ, 16'h0021, 16'd5, CLS_SIM, 1'b0);
    repeat (3) send_request(KIND_DEQ, 16'h0, 16'h0, 3'd0, 1'b0);

    // maximum limit: fill to the slot limit under receiver back-pressure
    set_limit(22'h3fffff);
    hold_off = 300;
    repeat (80) random_request(90);
    repeat (80) random_request(30);

    // random phases over several limits, one stretch with no idling
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       set_limit(22'd4000);
        1:       set_limit(LIMIT_RESET);
        2:       set_limit(22'($urandom));
        3:       set_limit(22'd1);
        default: set_limit(22'($urandom_range(200000)));
      endcase
      calm = (ph == 4);
      repeat (110) random_request(ph == 3 ? 70 : 55);
    end
    calm = 1'b0;

    drain();
    $display("covered %0d results: %0d drops, %0d empty dequeues, six limit phases",
             board.n_results, board.n_drops, board.n_empty);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", board.mismatches,
               board.pending.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
